### rtl/core/pbmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the protobuf media type classifier core.
// No dependencies; imported by every module of the block.
package pbmc_pkg;

   localparam int SkipCountWidthDefault = 32;

   localparam int TypeFieldWidth = 29;
   localparam int TypeValueWidth = 32;
   localparam int ValueWidth     = 64;
   localparam int CsrDataWidth   = 32;
   localparam int CsrIndexWidth  = 2;

   // Last byte index a varint may use before it is malformed.
   localparam logic [3:0] VarintLastIndex = 4'd9;

   typedef enum logic [2:0] {
      PH_TAG         = 3'd0,
      PH_SKIP_VARINT = 3'd1,
      PH_LENGTH      = 3'd2,
      PH_TYPE_VALUE  = 3'd3,
      PH_SKIP_BYTES  = 3'd4,
      PH_DONE        = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_UNDECIDED = 2'd0,
      VERDICT_FAILED    = 2'd1,
      VERDICT_FOUND     = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      WIRE_VARINT  = 3'd0,
      WIRE_FIXED64 = 3'd1,
      WIRE_LENGTH  = 3'd2,
      WIRE_FIXED32 = 3'd5
   } wire_code_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_VIDEO = 2'd1,
      KIND_AUDIO = 2'd2
   } media_kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TYPE_FIELD  = 2'd0,
      CSR_VIDEO_VALUE = 2'd1,
      CSR_AUDIO_VALUE = 2'd2,
      CSR_VOICE_VALUE = 2'd3
   } csr_index_type;

   // One finished message: whether the type field was read, and its value.
   typedef struct packed {
      logic                  found;
      logic [ValueWidth-1:0] value;
   } result_type;

endpackage

### rtl/core/protobuf_media_type_classifier_core.sv
`timescale 1ns / 1ps
// Top level of the protobuf media type classifier: CSRs, parser, result buffer.
// Depends on pbmc_pkg, pbmc_parser and pbmc_out_buf.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   req     | in        | req_valid/ready    | data_byte[7:0], last_byte
//   rsp     | out       | rsp_valid/ready    | media_kind[1:0], type_found, type_value
//   csr     | in        | csr_write_enable   | csr_index[1:0], csr_write_data[31:0]
//
// One byte is taken per cycle while req_ready is high; parser state updates at the
// accepting edge, and a last byte's result is registered at that same edge, in the
// output (or, if held, skid) register; rsp_valid is high from the next cycle on.
// Reset is synchronous: parser back to tag scan, type field number 1, values 0.
// The output register and a skid register hold up to two results; req_ready
// drops only when both are full, and while it is low every byte waits, last or not.
// The media kind is compared against the CSRs at the output register.
module protobuf_media_type_classifier_core #(
   parameter int SKIP_COUNT_WIDTH = pbmc_pkg::SkipCountWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_media_kind,
   output logic                                rsp_type_found,
   output logic [pbmc_pkg::ValueWidth-1:0]     rsp_type_value,
   input  logic                                csr_write_enable,
   input  logic [pbmc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pbmc_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import pbmc_pkg::*;

   logic [TypeFieldWidth-1:0] type_field_ff;
   logic [TypeValueWidth-1:0] video_value_ff;
   logic [TypeValueWidth-1:0] audio_value_ff;
   logic [TypeValueWidth-1:0] voice_value_ff;

   logic           byte_accept;
   logic           result_valid;
   logic           can_push;
   result_type     result;
   result_type     out_data;
   media_kind_type kind;

   // CSRs, which the user must write only while the block is idle; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         type_field_ff  <= TypeFieldWidth'(1);
         video_value_ff <= '0;
         audio_value_ff <= '0;
         voice_value_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TYPE_FIELD:  type_field_ff  <= csr_write_data[TypeFieldWidth-1:0];
            CSR_VIDEO_VALUE: video_value_ff <= csr_write_data[TypeValueWidth-1:0];
            CSR_AUDIO_VALUE: audio_value_ff <= csr_write_data[TypeValueWidth-1:0];
            CSR_VOICE_VALUE: voice_value_ff <= csr_write_data[TypeValueWidth-1:0];
            default: ;
         endcase
      end
   end

   // Hold off only while both result slots are occupied.
   assign req_ready   = can_push;
   assign byte_accept = req_valid && req_ready;

   pbmc_parser #(
      .SKIP_COUNT_WIDTH(SKIP_COUNT_WIDTH)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .byte_accept       (byte_accept),
      .data_byte         (req_data_byte),
      .last_byte         (req_last_byte),
      .type_field_number (type_field_ff),
      .result_valid      (result_valid),
      .result            (result)
   );

   pbmc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .can_push  (can_push),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   // Video wins over audio and voice; a found value matching none gives none.
   always_comb begin
      kind = KIND_NONE;
      if (out_data.found) begin
         if (out_data.value == {{(ValueWidth-TypeValueWidth){1'b0}}, video_value_ff}) begin
            kind = KIND_VIDEO;
         end else if (out_data.value ==
                         {{(ValueWidth-TypeValueWidth){1'b0}}, audio_value_ff} ||
                      out_data.value ==
                         {{(ValueWidth-TypeValueWidth){1'b0}}, voice_value_ff}) begin
            kind = KIND_AUDIO;
         end
      end
   end

   assign rsp_media_kind = kind;
   assign rsp_type_found = out_data.found;
   assign rsp_type_value = out_data.value;

endmodule

### rtl/core/pbmc_parser.sv
`timescale 1ns / 1ps
// Byte-at-a-time protobuf field scanner: tag/varint decode, skip, type capture.
// Depends on pbmc_pkg.
module pbmc_parser #(
   parameter int SKIP_COUNT_WIDTH = pbmc_pkg::SkipCountWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 byte_accept,
   input  logic [7:0]                           data_byte,
   input  logic                                 last_byte,
   input  logic [pbmc_pkg::TypeFieldWidth-1:0]  type_field_number,
   output logic                                 result_valid,
   output pbmc_pkg::result_type                 result
);
   import pbmc_pkg::*;

   phase_type                   phase_ff, phase_in;
   verdict_type                 verdict_ff, verdict_in;
   logic [ValueWidth-1:0]       acc_ff, acc_in;
   logic [3:0]                  idx_ff, idx_in;
   logic [SKIP_COUNT_WIDTH-1:0] skip_ff, skip_in;

   logic [ValueWidth-1:0]       acc_or;
   logic [ValueWidth-1:0]       shifted;
   logic [5:0]                  shift_amt;
   logic                        more;
   logic                        varint_bad;
   logic [2:0]                  wire_code;
   logic [SKIP_COUNT_WIDTH-1:0] len_sat;

   assign more       = data_byte[7];
   assign shift_amt  = 6'(idx_ff) * 6'd7;
   assign varint_bad = more && (idx_ff >= VarintLastIndex);
   assign wire_code  = acc_or[2:0];

   always_comb begin
      if (idx_ff < VarintLastIndex) begin
         shifted = {{(ValueWidth-7){1'b0}}, data_byte[6:0]} << shift_amt;
      end else begin
         // tenth byte: keep only its lowest payload bit
         shifted = {data_byte[0], {(ValueWidth-1){1'b0}}};
      end
      acc_or = acc_ff | shifted;
      if ((acc_or >> SKIP_COUNT_WIDTH) != '0) begin
         len_sat = '1;
      end else begin
         len_sat = acc_or[SKIP_COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      verdict_in = verdict_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      skip_in    = skip_ff;
      unique case (phase_ff)
         PH_TAG, PH_SKIP_VARINT, PH_LENGTH, PH_TYPE_VALUE: begin
            if (varint_bad) begin
               verdict_in = VERDICT_FAILED;
               phase_in   = PH_DONE;
            end else if (!more) begin
               acc_in = '0;
               idx_in = '0;
               if (phase_ff == PH_TAG) begin
                  if (acc_or == '0) begin
                     verdict_in = VERDICT_FAILED;
                     phase_in   = PH_DONE;
                  end else if (acc_or[34:3] == 32'(type_field_number)) begin
                     if (wire_code == WIRE_VARINT) begin
                        phase_in = PH_TYPE_VALUE;
                     end else begin
                        verdict_in = VERDICT_FAILED;
                        phase_in   = PH_DONE;
                     end
                  end else begin
                     case (wire_code)
                        WIRE_VARINT:  phase_in = PH_SKIP_VARINT;
                        WIRE_LENGTH:  phase_in = PH_LENGTH;
                        WIRE_FIXED64: begin
                           skip_in  = SKIP_COUNT_WIDTH'(4'd8);
                           phase_in = PH_SKIP_BYTES;
                        end
                        WIRE_FIXED32: begin
                           skip_in  = SKIP_COUNT_WIDTH'(4'd4);
                           phase_in = PH_SKIP_BYTES;
                        end
                        default: begin
                           verdict_in = VERDICT_FAILED;
                           phase_in   = PH_DONE;
                        end
                     endcase
                  end
               end else if (phase_ff == PH_SKIP_VARINT) begin
                  phase_in = PH_TAG;
               end else if (phase_ff == PH_LENGTH) begin
                  skip_in  = len_sat;
                  phase_in = (len_sat == '0) ? PH_TAG : PH_SKIP_BYTES;
               end else begin
                  // hold the type value until the last byte
                  acc_in     = acc_or;
                  verdict_in = VERDICT_FOUND;
                  phase_in   = PH_DONE;
               end
            end else begin
               acc_in = acc_or;
               idx_in = idx_ff + 4'd1;
            end
         end
         PH_SKIP_BYTES: begin
            skip_in = skip_ff - SKIP_COUNT_WIDTH'(1'b1);
            if (skip_ff == SKIP_COUNT_WIDTH'(1'b1)) begin
               phase_in = PH_TAG;
            end
         end
         default: ;
      endcase
   end

   assign result_valid = byte_accept && last_byte;
   assign result.found = (verdict_in == VERDICT_FOUND);
   assign result.value = (verdict_in == VERDICT_FOUND) ? acc_in : '0;

   always_ff @(posedge clock) begin
      if (reset || (byte_accept && last_byte)) begin
         phase_ff   <= PH_TAG;
         verdict_ff <= VERDICT_UNDECIDED;
         acc_ff     <= '0;
         idx_ff     <= '0;
         skip_ff    <= '0;
      end else if (byte_accept) begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
         acc_ff     <= acc_in;
         idx_ff     <= idx_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

### rtl/core/pbmc_out_buf.sv
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
// Depends on pbmc_pkg.
module pbmc_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pbmc_pkg::result_type push_data,
   output logic                 can_push,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pbmc_pkg::result_type out_data
);
   import pbmc_pkg::*;

   result_type main_ff;
   result_type skid_ff;
   logic       main_valid_ff;
   logic       skid_valid_ff;
   logic       main_take;

   assign main_take = !main_valid_ff || out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_take) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_take) begin
         main_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

### verif/pbmc_media_checker.sv
`timescale 1ns / 1ps
// Checker for the protobuf media type classifier: watches req, rsp and csr,
// predicts each classification and compares it with the rsp channel.
// Depends on pbmc_pkg only.
module pbmc_media_checker #(
   parameter int SKIP_COUNT_WIDTH = pbmc_pkg::SkipCountWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [1:0]                          rsp_media_kind,
   input  logic                                rsp_type_found,
   input  logic [pbmc_pkg::ValueWidth-1:0]     rsp_type_value,
   input  logic                                csr_write_enable,
   input  logic [pbmc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pbmc_pkg::CsrDataWidth-1:0]   csr_write_data,
   output int unsigned                         mismatch_count,
   output int unsigned                         awaited_count,
   output int unsigned                         checked_count
);
   import pbmc_pkg::*;

   localparam int ReportLimit = 10;
   localparam logic [63:0] SkipMax = (SKIP_COUNT_WIDTH >= 64) ? {64{1'b1}} :
                                     ((64'd1 << SKIP_COUNT_WIDTH) - 64'd1);

   typedef struct packed {
      media_kind_type        kind;
      logic                  found;
      logic [ValueWidth-1:0] value;
   } classification_type;

   classification_type awaited[$];

   logic [TypeFieldWidth-1:0] type_field;
   logic [TypeValueWidth-1:0] video_value;
   logic [TypeValueWidth-1:0] audio_value;
   logic [TypeValueWidth-1:0] voice_value;

   phase_type   scan_phase;
   logic [63:0] value_acc;
   logic [3:0]  group_idx;
   logic [63:0] skip_left;
   verdict_type outcome;

   function automatic void reset_scan();
      scan_phase = PH_TAG;
      value_acc  = '0;
      group_idx  = '0;
      skip_left  = '0;
      outcome    = VERDICT_UNDECIDED;
   endfunction

   function automatic void abandon();
      outcome    = VERDICT_FAILED;
      scan_phase = PH_DONE;
   endfunction

   function automatic void open_varint(phase_type next);
      value_acc  = '0;
      group_idx  = '0;
      scan_phase = next;
   endfunction

   function automatic void open_skip(logic [63:0] count);
      if (count > SkipMax) count = SkipMax;
      skip_left = count;
      value_acc = '0;
      group_idx = '0;
      if (count == 0) scan_phase = PH_TAG;
      else scan_phase = PH_SKIP_BYTES;
   endfunction

   function automatic void scan_byte(logic [7:0] b);
      logic done;
      logic bad;
      done = 1'b0;
      bad  = 1'b0;
      case (scan_phase)
         PH_TAG, PH_SKIP_VARINT, PH_LENGTH, PH_TYPE_VALUE: begin
            // the tenth group contributes bit 63 only
            if (group_idx < VarintLastIndex) value_acc |= {57'd0, b[6:0]} << (7 * group_idx);
            else value_acc[63] = value_acc[63] | b[0];
            if (!b[7]) done = 1'b1;
            else if (group_idx >= VarintLastIndex) bad = 1'b1;
            else group_idx = group_idx + 4'd1;
            if (bad) begin
               abandon();
            end else if (done) begin
               case (scan_phase)
                  PH_TAG: begin
                     if (value_acc == 0) begin
                        abandon();
                     end else if (value_acc[34:3] == {3'd0, type_field}) begin
                        if (value_acc[2:0] == WIRE_VARINT) open_varint(PH_TYPE_VALUE);
                        else abandon();
                     end else begin
                        case (value_acc[2:0])
                           WIRE_VARINT:  open_varint(PH_SKIP_VARINT);
                           WIRE_FIXED64: open_skip(64'd8);
                           WIRE_LENGTH:  open_varint(PH_LENGTH);
                           WIRE_FIXED32: open_skip(64'd4);
                           default:      abandon();
                        endcase
                     end
                  end
                  PH_SKIP_VARINT: open_varint(PH_TAG);
                  PH_LENGTH:      open_skip(value_acc);
                  default: begin
                     outcome    = VERDICT_FOUND;
                     scan_phase = PH_DONE;
                  end
               endcase
            end
         end
         PH_SKIP_BYTES: begin
            if (skip_left != 0) skip_left = skip_left - 64'd1;
            if (skip_left == 0) scan_phase = PH_TAG;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      classification_type want;
      classification_type made;
      if (reset) begin
         awaited.delete();
         type_field     = 29'd1;
         video_value    = '0;
         audio_value    = '0;
         voice_value    = '0;
         mismatch_count = 0;
         checked_count  = 0;
         reset_scan();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               if (mismatch_count < ReportLimit)
                  $display("unexpected result: kind %0d found %0b value %h",
                           rsp_media_kind, rsp_type_found, rsp_type_value);
               mismatch_count++;
            end else begin
               want = awaited.pop_front();
               checked_count++;
               if (rsp_media_kind !== want.kind || rsp_type_found !== want.found ||
                   rsp_type_value !== want.value) begin
                  if (mismatch_count < ReportLimit)
                     $display("result %0d differs: kind %0d/%0d found %0b/%0b value %h/%h",
                              checked_count, want.kind, rsp_media_kind, want.found,
                              rsp_type_found, want.value, rsp_type_value);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TYPE_FIELD:  type_field  = csr_write_data[TypeFieldWidth-1:0];
               CSR_VIDEO_VALUE: video_value = csr_write_data;
               CSR_AUDIO_VALUE: audio_value = csr_write_data;
               CSR_VOICE_VALUE: voice_value = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            scan_byte(req_data_byte);
            if (req_last_byte) begin
               made.kind  = KIND_NONE;
               made.found = (outcome == VERDICT_FOUND);
               made.value = made.found ? value_acc : '0;
               if (made.found) begin
                  // video wins over audio and voice
                  if (value_acc == {32'd0, video_value}) made.kind = KIND_VIDEO;
                  else if (value_acc == {32'd0, audio_value} ||
                           value_acc == {32'd0, voice_value}) made.kind = KIND_AUDIO;
               end
               awaited.push_back(made);
               reset_scan();
            end
         end
      end
      awaited_count = awaited.size();
   end

endmodule

### verif/tb_protobuf_media_type_classifier_core.sv
`timescale 1ns / 1ps
// Testbench top for protobuf_media_type_classifier_core: streams protobuf
// messages with random idling and register settings. Depends on pbmc_pkg,
// pbmc_media_checker and the core RTL.
module tb_protobuf_media_type_classifier_core;
   import pbmc_pkg::*;

   localparam int RandomPhases = 8;    // register settings after the directed part
   localparam int PhaseBytes   = 105;  // bytes streamed per setting
   localparam int SettleCycles = 4;    // quiet cycles before a register write
   localparam int DrainCycles  = 20;   // quiet cycles before the verdict

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte    = '0;
   logic                     req_last_byte    = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [1:0]               rsp_media_kind;
   logic                     rsp_type_found;
   logic [ValueWidth-1:0]    rsp_type_value;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index        = '0;
   logic [CsrDataWidth-1:0]  csr_write_data   = '0;

   int unsigned mismatches;
   int unsigned awaited;
   int unsigned checked;

   // Bytes of the message being built, sent front to back.
   logic [7:0]  msg_bytes[$];
   // Set for a whole message to run both channels without idling.
   logic        no_idle       = 1'b0;
   int unsigned bytes_sent    = 0;
   int unsigned messages_sent = 0;

   // Register values last written; the stimulus aims type values at them.
   logic [TypeFieldWidth-1:0] cfg_type  = 29'd1;
   logic [TypeValueWidth-1:0] cfg_video = '0;
   logic [TypeValueWidth-1:0] cfg_audio = '0;
   logic [TypeValueWidth-1:0] cfg_voice = '0;

   protobuf_media_type_classifier_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_media_kind   (rsp_media_kind),
      .rsp_type_found   (rsp_type_found),
      .rsp_type_value   (rsp_type_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pbmc_media_checker media_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_media_kind   (rsp_media_kind),
      .rsp_type_found   (rsp_type_found),
      .rsp_type_value   (rsp_type_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatches),
      .awaited_count    (awaited),
      .checked_count    (checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2_000_000;
      $display("protobuf_media_type_classifier_core test failed");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Extra zero groups appended to a varint now and then (non-minimal encoding).
   function automatic int unsigned pad_count();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   // Append v as a varint, stretched by pad groups, never past ten bytes.
   function automatic void add_varint(logic [63:0] v, int unsigned pad);
      logic [63:0] rest;
      int unsigned n;
      int unsigned k;
      rest = v;
      n = 1;
      while (rest >= 64'd128) begin
         rest = rest >> 7;
         n++;
      end
      n = n + pad;
      if (n > 10) n = 10;
      rest = v;
      for (k = 0; k < n; k++) begin
         msg_bytes.push_back({(k != n - 1), rest[6:0]});
         rest = rest >> 7;
      end
   endfunction

   function automatic void add_random_bytes(int unsigned n);
      repeat (n) msg_bytes.push_back(8'($urandom));
   endfunction

   // Bytes that all carry the continuation bit.
   function automatic void add_continuations(int unsigned n);
      repeat (n) msg_bytes.push_back({1'b1, 7'($urandom)});
   endfunction

   // Append one random field, skipped by wire type unless it hits the type field.
   function automatic void add_other_field();
      logic [31:0] fnum;
      logic [2:0]  wire_code;
      logic [63:0] tag;
      logic [63:0] len;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: fnum = {3'd0, 29'($urandom_range(1, 29'h1FFF_FFFF))};
         6, 7:             fnum = $urandom_range(1, 20);
         // same low 29 bits as the type field, but the upper tag bits differ
         8:                fnum = {3'($urandom_range(1, 7)), cfg_type};
         default:          fnum = '0;
      endcase
      case ($urandom_range(0, 3))
         0:       wire_code = WIRE_VARINT;
         1:       wire_code = WIRE_FIXED64;
         2:       wire_code = WIRE_LENGTH;
         default: wire_code = WIRE_FIXED32;
      endcase
      tag = {29'd0, fnum, wire_code};
      // tag bits above the field number are outside the compare
      if ($urandom_range(0, 15) == 0) tag[63:35] = 29'($urandom);
      add_varint(tag, pad_count());
      case (wire_code)
         WIRE_VARINT:  add_varint($urandom_range(0, 1) ? 64'($urandom_range(0, 200)) : rand64(),
                                  pad_count());
         WIRE_FIXED64: add_random_bytes(8);
         WIRE_FIXED32: add_random_bytes(4);
         default: begin
            if ($urandom_range(0, 19) == 0) begin
               // length past the skip counter: saturates, the message ends inside
               len = rand64() | (64'd1 << 32);
               add_varint(len, 0);
               add_random_bytes($urandom_range(0, 4));
            end else begin
               len = 64'($urandom_range(0, 6));
               add_varint(len, pad_count());
               add_random_bytes(32'(len));
            end
         end
      endcase
   endfunction

   // Stream msg_bytes with a random gap before each item, last byte marked.
   task automatic send_message();
      int unsigned gap;
      int unsigned k;
      for (k = 0; k < msg_bytes.size(); k++) begin
         gap = no_idle ? 0 : $urandom_range(0, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= msg_bytes[k];
         req_last_byte <= (k == msg_bytes.size() - 1);
         do @(posedge clock); while (!req_ready);
         bytes_sent++;
         @(negedge clock);
      end
      messages_sent++;
   endtask

   // Drop valid, wait for every awaited result, then idle for the cycles given.
   task automatic settle(int unsigned cycles);
      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   // Result sink: stall a random number of cycles before taking each item.
   initial begin : result_sink
      int unsigned stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned sel;
      int unsigned phase_start;
      int unsigned keep;
      logic [63:0] tag;
      logic [63:0] value;
      logic [28:0] new_type;
      logic [2:0]  wire_code;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset register values: type field 1, all type values 0.
      // Type value 0 is video; trailing bytes after the decision are ignored.
      msg_bytes = '{8'h08, 8'h00, 8'h13, 8'h00};
      send_message();
      // Zero tag.
      msg_bytes = '{8'h00};
      send_message();
      // Reserved wire types 3, 4, 6 and 7 on field 2.
      msg_bytes = '{8'h13};
      send_message();
      msg_bytes = '{8'h14};
      send_message();
      msg_bytes = '{8'h16};
      send_message();
      msg_bytes = '{8'h17};
      send_message();
      // Type field with a length-delimited wire type.
      msg_bytes = '{8'h0A, 8'h00};
      send_message();
      // Ten-byte type value: only bit 0 of the tenth byte survives, as bit 63.
      msg_bytes = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'h7F};
      send_message();
      // Tag varint whose tenth byte still continues.
      msg_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
      send_message();
      // Length-delimited field cut short.
      msg_bytes = '{8'h12, 8'h05, 8'hAA};
      send_message();

      for (phase = 1; phase <= RandomPhases; phase++) begin
         // Registers change only with the block idle and between messages.
         settle(SettleCycles);
         case (phase)
            1: begin
               new_type  = 29'd1;
               cfg_video = 32'd1;
               cfg_audio = 32'd2;
               cfg_voice = 32'd3;
            end
            2: begin
               new_type  = 29'h1FFF_FFFF;
               cfg_video = 32'hFFFF_FFFF;
               cfg_audio = '0;
               cfg_voice = $urandom;
            end
            3: begin
               new_type  = 29'($urandom_range(2, 30));
               cfg_video = $urandom_range(0, 300);
               cfg_audio = $urandom_range(0, 300);
               cfg_voice = $urandom;
            end
            4: begin
               // all three equal: video must win
               new_type  = 29'($urandom_range(1, 29'h1FFF_FFFF));
               cfg_video = $urandom_range(0, 300);
               cfg_audio = cfg_video;
               cfg_voice = cfg_video;
            end
            5: begin
               new_type  = 29'd2;
               cfg_video = $urandom;
               cfg_audio = $urandom_range(0, 300);
               cfg_voice = cfg_audio;
            end
            default: begin
               new_type  = $urandom_range(0, 1) ? 29'($urandom_range(1, 40))
                                                : 29'($urandom_range(1, 29'h1FFF_FFFF));
               cfg_video = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom;
               cfg_audio = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom;
               cfg_voice = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom;
            end
         endcase
         cfg_type = new_type;
         // upper write data bits of the type field register are don't-care
         write_register(CSR_TYPE_FIELD, {3'($urandom), cfg_type});
         write_register(CSR_VIDEO_VALUE, cfg_video);
         write_register(CSR_AUDIO_VALUE, cfg_audio);
         write_register(CSR_VOICE_VALUE, cfg_voice);
         csr_write_enable <= 1'b0;

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PhaseBytes) begin
            msg_bytes.delete();
            no_idle = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
               // Well-formed message carrying the type field, some cut short.
               repeat ($urandom_range(0, 3)) add_other_field();
               tag = {29'd0, 3'd0, cfg_type, 3'(WIRE_VARINT)};
               if ($urandom_range(0, 7) == 0) tag[63:35] = 29'($urandom) | 29'd1;
               add_varint(tag, pad_count());
               case ($urandom_range(0, 9))
                  0:       value = {32'd0, cfg_video};
                  1:       value = {32'd0, cfg_audio};
                  2:       value = {32'd0, cfg_voice};
                  3:       value = 64'($urandom_range(0, 300));
                  4:       value = {32'd0, $urandom};
                  5:       value = rand64();
                  // matches video in the low half only
                  6:       value = {$urandom | 32'd1, cfg_video};
                  7:       value = '0;
                  8:       value = '1;
                  default: value = '0;
               endcase
               if (value == '0 && $urandom_range(0, 1)) begin
                  // ten-byte value with random payload in the tenth byte
                  add_continuations(9);
                  msg_bytes.push_back({1'b0, 7'($urandom)});
               end else begin
                  add_varint(value, pad_count());
               end
               repeat ($urandom_range(0, 2)) add_other_field();
               if ($urandom_range(0, 3) == 0) add_random_bytes($urandom_range(1, 4));
               if (sel >= 55 && msg_bytes.size() > 1) begin
                  keep = $urandom_range(1, msg_bytes.size() - 1);
                  while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
               end
            end else if (sel < 80) begin
               // Other fields only, with no deliberate type field.
               repeat ($urandom_range(1, 3)) add_other_field();
            end else if (sel < 92) begin
               // Broken message after a valid prefix, then noise.
               repeat ($urandom_range(0, 2)) add_other_field();
               case ($urandom_range(0, 4))
                  0: begin
                     case ($urandom_range(0, 3))
                        0:       wire_code = 3'd3;
                        1:       wire_code = 3'd4;
                        2:       wire_code = 3'd6;
                        default: wire_code = 3'd7;
                     endcase
                     tag = {29'd0, 3'd0, 29'($urandom_range(1, 1000)), wire_code};
                     add_varint(tag, pad_count());
                  end
                  1: add_varint(64'd0, pad_count());
                  2: begin
                     tag = {29'd0, 3'd0, cfg_type, 3'($urandom_range(1, 7))};
                     add_varint(tag, pad_count());
                  end
                  3: add_continuations(10);
                  default: begin
                     tag = {29'd0, 3'd0, cfg_type, 3'(WIRE_VARINT)};
                     add_varint(tag, 0);
                     add_continuations(10);
                  end
               endcase
               add_random_bytes($urandom_range(0, 3));
            end else begin
               // Plain noise.
               add_random_bytes($urandom_range(1, 12));
            end
            send_message();
         end
      end

      settle(DrainCycles);
      $display("streamed %0d bytes in %0d messages over %0d register settings",
               bytes_sent, messages_sent, RandomPhases + 1);
      $display("checked %0d classifications, %0d mismatches", checked, mismatches);
      if (mismatches == 0 && awaited == 0) begin
         $display("protobuf_media_type_classifier_core test passed");
      end else begin
         $display("protobuf_media_type_classifier_core test failed");
      end
      $finish;
   end

endmodule
